>>> src/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants for the rotation matrix to quaternion block.
// ----------------------------------------------------------------------------
package rmq_pkg;

	localparam int FRAC_BITS_DEF = 14;
	localparam int ELEM_W = 16;
	localparam int D_W = 17;

	localparam logic [1:0] LEAD_X = 2'd0;
	localparam logic [1:0] LEAD_Y = 2'd1;
	localparam logic [1:0] LEAD_Z = 2'd2;
	localparam logic [1:0] LEAD_W = 2'd3;

	typedef struct packed {
		logic                  zero;
		logic [1:0]            lead;
		logic signed [D_W-1:0] d0;
		logic signed [D_W-1:0] d1;
		logic signed [D_W-1:0] d2;
	} rmq_side_t;

endpackage

>>> src/rmq_front.sv
// ----------------------------------------------------------------------------
// rmq_front
// Branch selection, t and off-diagonal sums and differences, one register stage.
// ----------------------------------------------------------------------------
module rmq_front #(
	parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
	parameter int TW = 19
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    vld_in,
	input  logic [143:0]            elems,
	output logic                    vld_s1,
	output logic [TW-1:0]           t_s1,
	output rmq_pkg::rmq_side_t      side_s1
);
	localparam int EW = rmq_pkg::ELEM_W;
	localparam int DW = rmq_pkg::D_W;
	localparam int TS = TW + 1;

	logic signed [EW-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
	logic signed [TS-1:0] e00, e11, e22, one, t_c;
	logic signed [DW+1:0] trace;
	rmq_pkg::rmq_side_t   side_c;

	assign r00 = elems[15:0];
	assign r01 = elems[31:16];
	assign r02 = elems[47:32];
	assign r10 = elems[63:48];
	assign r11 = elems[79:64];
	assign r12 = elems[95:80];
	assign r20 = elems[111:96];
	assign r21 = elems[127:112];
	assign r22 = elems[143:128];

	assign e00 = TS'(r00);
	assign e11 = TS'(r11);
	assign e22 = TS'(r22);
	assign one = TS'(1) <<< FRAC_BITS;
	assign trace = (DW+2)'(r00) + (DW+2)'(r11) + (DW+2)'(r22);

	always_comb begin
		if (trace > 0) begin
			t_c = one + e00 + e11 + e22;
			side_c.lead = rmq_pkg::LEAD_W;
			side_c.d0 = DW'(r12) - DW'(r21);
			side_c.d1 = DW'(r20) - DW'(r02);
			side_c.d2 = DW'(r01) - DW'(r10);
		end else if (r00 > r11 && r00 > r22) begin
			t_c = one + e00 - e11 - e22;
			side_c.lead = rmq_pkg::LEAD_X;
			side_c.d0 = DW'(r01) + DW'(r10);
			side_c.d1 = DW'(r20) + DW'(r02);
			side_c.d2 = DW'(r12) - DW'(r21);
		end else if (r11 > r22) begin
			t_c = one - e00 + e11 - e22;
			side_c.lead = rmq_pkg::LEAD_Y;
			side_c.d0 = DW'(r01) + DW'(r10);
			side_c.d1 = DW'(r12) + DW'(r21);
			side_c.d2 = DW'(r20) - DW'(r02);
		end else begin
			t_c = one - e00 - e11 + e22;
			side_c.lead = rmq_pkg::LEAD_Z;
			side_c.d0 = DW'(r20) + DW'(r02);
			side_c.d1 = DW'(r12) + DW'(r21);
			side_c.d2 = DW'(r01) - DW'(r10);
		end
		side_c.zero = (t_c <= 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1 <= side_c.zero ? TW'(1) : t_c[TW-1:0];
			side_s1 <= side_c;
		end
	end
endmodule

>>> src/rmq_sqrt.sv
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined integer square root of t * 2^F, one root bit per stage.
// ----------------------------------------------------------------------------
module rmq_sqrt #(
	parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
	parameter int TW = 19,
	parameter int HW = 17
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    vld_in,
	input  logic [TW-1:0]           t_in,
	input  rmq_pkg::rmq_side_t      side_in,
	output logic                    vld_out,
	output logic [TW-1:0]           t_out,
	output logic [HW-1:0]           root_out,
	output rmq_pkg::rmq_side_t      side_out
);
	localparam int SW = 2 * HW;

	logic               vld_q  [HW+1];
	logic [TW-1:0]      t_q    [HW+1];
	logic [HW-1:0]      root_q [HW+1];
	logic [HW+1:0]      rem_q  [HW+1];
	logic [SW-1:0]      val_q  [HW+1];
	rmq_pkg::rmq_side_t side_q [HW+1];

	assign vld_q[0]  = vld_in;
	assign t_q[0]    = t_in;
	assign root_q[0] = '0;
	assign rem_q[0]  = '0;
	assign val_q[0]  = SW'(t_in) << FRAC_BITS;
	assign side_q[0] = side_in;

	for (genvar i = 0; i < HW; i++) begin : g_stage
		logic [HW+3:0] sh;
		logic [HW+3:0] trial;
		logic          take;

		assign sh = {rem_q[i], val_q[i][SW-1:SW-2]};
		assign trial = {2'b00, root_q[i], 2'b01};
		assign take = (sh >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[i+1] <= 1'b0;
			end else if (en) begin
				vld_q[i+1] <= vld_q[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				t_q[i+1] <= t_q[i];
				side_q[i+1] <= side_q[i];
				val_q[i+1] <= val_q[i] << 2;
				if (take) begin
					rem_q[i+1] <= (HW+2)'(sh - trial);
					root_q[i+1] <= {root_q[i][HW-2:0], 1'b1};
				end else begin
					rem_q[i+1] <= sh[HW+1:0];
					root_q[i+1] <= {root_q[i][HW-2:0], 1'b0};
				end
			end
		end
	end

	assign vld_out  = vld_q[HW];
	assign t_out    = t_q[HW];
	assign root_out = root_q[HW];
	assign side_out = side_q[HW];
endmodule

>>> src/rmq_div.sv
// ----------------------------------------------------------------------------
// rmq_div
// Pipelined restoring division giving s = 2^(2F-1) / root, rounded half up.
// ----------------------------------------------------------------------------
module rmq_div #(
	parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
	parameter int TW = 19,
	parameter int HW = 17
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    vld_in,
	input  logic [TW-1:0]           t_in,
	input  logic [HW-1:0]           root_in,
	input  rmq_pkg::rmq_side_t      side_in,
	output logic                    vld_out,
	output logic [TW-1:0]           t_out,
	output logic [2*FRAC_BITS-1:0]  s_out,
	output rmq_pkg::rmq_side_t      side_out
);
	localparam int NW = 2 * FRAC_BITS;
	localparam int RW = HW + 1;

	logic               vld_q  [NW+1];
	logic [TW-1:0]      t_q    [NW+1];
	logic [HW-1:0]      den_q  [NW+1];
	logic [RW-1:0]      rem_q  [NW+1];
	logic [NW-1:0]      num_q  [NW+1];
	logic [NW-1:0]      quo_q  [NW+1];
	rmq_pkg::rmq_side_t side_q [NW+1];

	assign vld_q[0]  = vld_in;
	assign t_q[0]    = t_in;
	assign den_q[0]  = root_in;
	assign rem_q[0]  = '0;
	assign num_q[0]  = (NW'(1) << (NW - 1)) + NW'(root_in >> 1);
	assign quo_q[0]  = '0;
	assign side_q[0] = side_in;

	for (genvar i = 0; i < NW; i++) begin : g_stage
		logic [RW:0] sh;
		logic        take;

		assign sh = {rem_q[i], num_q[i][NW-1]};
		assign take = (sh >= (RW+1)'(den_q[i]));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[i+1] <= 1'b0;
			end else if (en) begin
				vld_q[i+1] <= vld_q[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				t_q[i+1] <= t_q[i];
				den_q[i+1] <= den_q[i];
				side_q[i+1] <= side_q[i];
				num_q[i+1] <= num_q[i] << 1;
				quo_q[i+1] <= {quo_q[i][NW-2:0], take};
				if (take) begin
					rem_q[i+1] <= RW'(sh - (RW+1)'(den_q[i]));
				end else begin
					rem_q[i+1] <= sh[RW-1:0];
				end
			end
		end
	end

	assign vld_out  = vld_q[NW];
	assign t_out    = t_q[NW];
	assign s_out    = quo_q[NW];
	assign side_out = side_q[NW];
endmodule

>>> src/rmq_out.sv
// ----------------------------------------------------------------------------
// rmq_out
// Four scaling multipliers, then rounding, saturation and the output register.
// ----------------------------------------------------------------------------
module rmq_out #(
	parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
	parameter int TW = 19
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    vld_in,
	input  logic [TW-1:0]           t_in,
	input  logic [2*FRAC_BITS-1:0]  s_in,
	input  rmq_pkg::rmq_side_t      side_in,
	output logic                    vld_out,
	output logic [63:0]             quat
);
	localparam int NW = 2 * FRAC_BITS;
	localparam int MW = TW + 1;
	localparam int PW = NW + 1 + MW;

	logic signed [MW-1:0] tm, dm0, dm1, dm2;
	logic signed [MW-1:0] mul [4];
	logic signed [NW:0]   sm;
	logic signed [PW-1:0] prod_s1 [4];
	logic                 zero_s1;
	logic                 vld_s1;
	logic [15:0]          res [4];
	logic [15:0]          res_s2 [4];

	assign tm  = MW'(signed'({1'b0, t_in}));
	assign dm0 = MW'(side_in.d0);
	assign dm1 = MW'(side_in.d1);
	assign dm2 = MW'(side_in.d2);
	assign sm  = signed'({1'b0, s_in});

	always_comb begin
		mul[0] = (side_in.lead == rmq_pkg::LEAD_X) ? tm : dm0;
		case (side_in.lead)
			rmq_pkg::LEAD_X: mul[1] = dm0;
			rmq_pkg::LEAD_Y: mul[1] = tm;
			default:         mul[1] = dm1;
		endcase
		case (side_in.lead)
			rmq_pkg::LEAD_Z: mul[2] = tm;
			rmq_pkg::LEAD_W: mul[2] = dm2;
			default:         mul[2] = dm1;
		endcase
		mul[3] = (side_in.lead == rmq_pkg::LEAD_W) ? tm : dm2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_out <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_out <= vld_s1;
		end
	end

	for (genvar k = 0; k < 4; k++) begin : g_comp
		logic signed [PW-1:0] rnd;
		logic signed [PW-1:0] q;
		logic signed [PW-1:0] lim;

		assign lim = PW'(1) <<< FRAC_BITS;
		assign rnd = prod_s1[k] + (PW'(1) <<< (FRAC_BITS - 1));
		assign q = rnd >>> FRAC_BITS;

		always_comb begin
			if (zero_s1) begin
				res[k] = '0;
			end else if (q > lim) begin
				res[k] = lim[15:0];
			end else if (q < -lim) begin
				res[k] = 16'(-lim);
			end else begin
				res[k] = q[15:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				prod_s1[k] <= PW'(sm) * PW'(mul[k]);
				res_s2[k] <= res[k];
			end
		end
	end

	assign quat = {res_s2[3], res_s2[2], res_s2[1], res_s2[0]};

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s1 <= side_in.zero;
		end
	end
endmodule

>>> src/rotation_matrix_to_quaternion.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// The pipeline is the front register, one square root stage per root bit,
// one divider stage per quotient bit, then the multiplier and output registers.
// Throughput is one item per cycle; a stall freezes the whole pipeline.
// Reset clears only the valid bits of every stage.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion #(
	parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// r00, r01, r02, r10, r11, r12, r20, r21, r22, 16 bits each
	input  logic [143:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// quat_x, quat_y, quat_z, quat_w, 16 bits each
	output logic [63:0]  m_tdata
);
	localparam int TW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
	localparam int VW = TW + FRAC_BITS;
	localparam int HW = (VW + 1) / 2;

	logic               en;
	logic               vld_a, vld_b, vld_c;
	logic [TW-1:0]      t_a, t_b, t_c;
	logic [HW-1:0]      root_b;
	logic [2*FRAC_BITS-1:0] s_c;
	rmq_pkg::rmq_side_t side_a, side_b, side_c;

	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	rmq_front #(.FRAC_BITS(FRAC_BITS), .TW(TW)) u_front (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_in(s_tvalid), .elems(s_tdata),
		.vld_s1(vld_a), .t_s1(t_a), .side_s1(side_a)
	);

	rmq_sqrt #(.FRAC_BITS(FRAC_BITS), .TW(TW), .HW(HW)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_in(vld_a), .t_in(t_a), .side_in(side_a),
		.vld_out(vld_b), .t_out(t_b), .root_out(root_b), .side_out(side_b)
	);

	rmq_div #(.FRAC_BITS(FRAC_BITS), .TW(TW), .HW(HW)) u_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_in(vld_b), .t_in(t_b), .root_in(root_b), .side_in(side_b),
		.vld_out(vld_c), .t_out(t_c), .s_out(s_c), .side_out(side_c)
	);

	rmq_out #(.FRAC_BITS(FRAC_BITS), .TW(TW)) u_out (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_in(vld_c), .t_in(t_c), .s_in(s_c), .side_in(side_c),
		.vld_out(m_tvalid), .quat(m_tdata)
	);
endmodule

>>> bench/rmq_checker.sv
// ----------------------------------------------------------------------------
// rmq_checker
// Watches both streams of the rotation matrix to quaternion block, computes
// the quaternion expected for every accepted matrix and compares it with the
// items that leave the block, in order.
// ----------------------------------------------------------------------------
module rmq_checker #(
	parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [143:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [63:0]  m_tdata,
	output int           errors,
	output int           pending,
	output int           received,
	output int           lead_hits [4]
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [63:0] quat_t;

	quat_t quat_queue[$];

	function automatic logic [15:0] round_sat(input longint p);
		longint one;
		longint q;
		begin
			one = longint'(1) << FRAC_BITS;
			q = (p + (one >>> 1)) >>> FRAC_BITS;
			if (q > one)
				q = one;
			if (q < -one)
				q = -one;
			return q[15:0];
		end
	endfunction

	function automatic longint root_floor(input longint v);
		longint r;
		begin
			r = 0;
			for (int b = 31; b >= 0; b--) begin
				if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= v)
					r = r + (longint'(1) << b);
			end
			return r;
		end
	endfunction

	function automatic quat_t quat_of(input logic [143:0] d, output logic [1:0] lead);
		longint e [9];
		longint one, t, a, b, c, rt, sc;
		longint q [4];
		begin
			one = longint'(1) << FRAC_BITS;
			for (int k = 0; k < 9; k++)
				e[k] = longint'($signed(d[16*k +: 16]));
			if (e[0] + e[4] + e[8] > 0) begin
				t = one + e[0] + e[4] + e[8];
				lead = rmq_pkg::LEAD_W;
				a = e[5] - e[7]; b = e[6] - e[2]; c = e[1] - e[3];
			end else if (e[0] > e[4] && e[0] > e[8]) begin
				t = one + e[0] - e[4] - e[8];
				lead = rmq_pkg::LEAD_X;
				a = e[1] + e[3]; b = e[6] + e[2]; c = e[5] - e[7];
			end else if (e[4] > e[8]) begin
				t = one - e[0] + e[4] - e[8];
				lead = rmq_pkg::LEAD_Y;
				a = e[1] + e[3]; b = e[5] + e[7]; c = e[6] - e[2];
			end else begin
				t = one - e[0] - e[4] + e[8];
				lead = rmq_pkg::LEAD_Z;
				a = e[6] + e[2]; b = e[5] + e[7]; c = e[1] - e[3];
			end
			if (t <= 0)
				return '0;
			rt = root_floor(t << FRAC_BITS);
			if (rt == 0)
				rt = 1;
			sc = ((longint'(1) << (2 * FRAC_BITS - 1)) + (rt >>> 1)) / rt;
			case (lead)
				rmq_pkg::LEAD_W: begin
					q[3] = sc * t; q[0] = a * sc; q[1] = b * sc; q[2] = c * sc;
				end
				rmq_pkg::LEAD_X: begin
					q[0] = sc * t; q[1] = a * sc; q[2] = b * sc; q[3] = c * sc;
				end
				rmq_pkg::LEAD_Y: begin
					q[1] = sc * t; q[0] = a * sc; q[2] = b * sc; q[3] = c * sc;
				end
				default: begin
					q[2] = sc * t; q[0] = a * sc; q[1] = b * sc; q[3] = c * sc;
				end
			endcase
			return {round_sat(q[3]), round_sat(q[2]), round_sat(q[1]), round_sat(q[0])};
		end
	endfunction

	assign pending = quat_queue.size();

	always @(posedge clk or negedge arst_n) begin
		quat_t want;
		logic [1:0] lead;
		if (!arst_n) begin
			errors <= 0;
			received <= 0;
			for (int k = 0; k < 4; k++)
				lead_hits[k] <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				quat_queue.push_back(quat_of(s_tdata, lead));
				lead_hits[lead] <= lead_hits[lead] + 1;
			end
			if (m_tvalid && m_tready) begin
				received <= received + 1;
				if (quat_queue.size() == 0) begin
					if (errors < 10)
						$display("Unexpected item %h", m_tdata);
					errors <= errors + 1;
				end else begin
					want = quat_queue.pop_front();
					if (want !== m_tdata) begin
						if (errors < 10)
							$display("Mismatch x/y/z/w: expected %h %h %h %h, got %h %h %h %h",
								want[15:0], want[31:16], want[47:32], want[63:48],
								m_tdata[15:0], m_tdata[31:16], m_tdata[47:32],
								m_tdata[63:48]);
						errors <= errors + 1;
					end
				end
			end
		end
	end
endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Streams directed and random 3x3 matrices into the block with random
// gaps and output stalls; the checker predicts and compares every quaternion.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM = 1930;
	localparam int LATENCY = 60;
	localparam longint LIMIT = 400000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [143:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [63:0]  m_tdata;
	int           errors, pending, received;
	int           lead_hits [4];
	longint       cycles = 0;
	logic         stim_done = 1'b0;
	bit           calm = 1'b0;
	int           out_wait = 0;

	always #1 clk = ~clk;

	rotation_matrix_to_quaternion i_dut (.*);

	rmq_checker i_chk (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		int w;
		if (m_tvalid && m_tready) begin
			w = calm ? 0 : $urandom_range(7);
			m_tready <= (w == 0);
			out_wait <= (w == 0) ? 0 : w - 1;
		end else if (!m_tready) begin
			if (out_wait == 0)
				m_tready <= 1'b1;
			else
				out_wait <= out_wait - 1;
		end
	end

	function automatic logic [15:0] elem_rand();
		case ($urandom_range(9))
			0: return 16'h4000;
			1: return 16'hC000;
			2: return 16'(0);
			3: return 16'($urandom);
			default: return 16'($signed($urandom_range(32768)) - 16384);
		endcase
	endfunction

	task automatic send_item(input logic [143:0] d);
		int gap;
		gap = calm ? 0 : $urandom_range(7);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	function automatic logic [143:0] pack9(input logic [15:0] e [9]);
		logic [143:0] d;
		for (int k = 0; k < 9; k++)
			d[16*k +: 16] = e[k];
		return d;
	endfunction

	task automatic send_diag(input int a, input int b, input int c, input int off);
		logic [15:0] e [9];
		for (int k = 0; k < 9; k++)
			e[k] = 16'(off * (k + 1));
		e[0] = 16'(a); e[4] = 16'(b); e[8] = 16'(c);
		send_item(pack9(e));
	endtask

	initial begin
		logic [15:0] e [9];
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_diag(16384, 16384, 16384, 0);
		send_diag(16384, -16384, -16384, 0);
		send_diag(-16384, 16384, -16384, 0);
		send_diag(-16384, -16384, 16384, 0);
		send_diag(0, 0, 0, 0);
		send_diag(-16384, -16384, -16384, 0);
		send_diag(-32768, -32768, -32768, 7);
		send_diag(32767, 32767, 32767, -7);
		send_diag(5000, 5000, -10000, 300);
		send_diag(-3000, -3000, -3000, 1000);
		send_diag(-100, -5000, -5000, 2000);
		send_diag(-5000, 100, 100, -2000);
		send_diag(-9000, -9000, 200, 4000);
		send_diag(-16384, -16383, -16384, 0);
		for (int k = 0; k < 9; k++) e[k] = 16'h7FFF;
		send_item(pack9(e));
		for (int k = 0; k < 9; k++) e[k] = 16'h8000;
		send_item(pack9(e));
		for (int k = 0; k < 9; k++) e[k] = 16'hFFFF;
		send_item(pack9(e));
		calm = 1'b1;
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == 150)
				calm = 1'b0;
			if (n == 1700)
				calm = 1'b1;
			for (int k = 0; k < 9; k++)
				e[k] = elem_rand();
			send_item(pack9(e));
		end
		s_tvalid <= 1'b0;
		stim_done = 1'b1;
		calm = 1'b1;
		while (pending != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
		$display("Sent %0d matrices, received %0d quaternions", 17 + N_RANDOM, received);
		$display("Leading component x/y/z/w: %0d %0d %0d %0d",
			lead_hits[0], lead_hits[1], lead_hits[2], lead_hits[3]);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
